FILE: hdl/b64d_pkg.sv
// b64d_pkg: types and constants shared by the base64 stream decoder.
// No dependencies; compiled first.
package b64d_pkg;

   localparam int unsigned CHAR_W              = 8;
   localparam int unsigned CSR_INDEX_W         = 2;
   localparam int unsigned GROUP_W             = 24;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Reset values of the configurable alphabet codes
   localparam logic [CHAR_W-1:0] CHAR_62_RESET = 8'd43;  // plus sign
   localparam logic [CHAR_W-1:0] CHAR_63_RESET = 8'd47;  // slash
   localparam logic [CHAR_W-1:0] PAD_RESET     = 8'd61;  // equals sign

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHAR_62 = 2'd0,
      CSR_CHAR_63 = 2'd1,
      CSR_PAD     = 2'd2
   } csr_index_type;

   // Status codes of a status result
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ILLEGAL = 2'd1,
      STATUS_LENGTH  = 2'd2
   } status_type;

   // One unit of work from the front end to the back end:
   // up to three bytes of a group, then an optional status result.
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [1:0]         byte_count;
      logic               has_status;
      status_type         status;
   } job_type;

endpackage

FILE: hdl/b64d_if.sv
// Channel interfaces of the base64 stream decoder: request, response, CSR.
// Depends on b64d_pkg for widths.
interface b64d_req_if import b64d_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_message;

   modport source (output valid, output char_code, output end_of_message, input ready);
   modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface b64d_rsp_if import b64d_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] data_byte;
   logic              is_status;
   logic [1:0]        status;
   logic              last_of_run;

   modport source (output valid, output data_byte, output is_status, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input data_byte, input is_status, input status,
                   input last_of_run, output ready);
endinterface

interface b64d_csr_if import b64d_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CHAR_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/base64_stream_decoder.sv
// base64_stream_decoder: top level, front end, job queue and back end.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+------------------------------------------
//   req_bus  | in        | valid / ready | char_code[7:0], end_of_message
//   rsp_bus  | out       | valid / ready | data_byte[7:0], is_status, status[1:0],
//            |           |               | last_of_run
//   csr_bus  | in        | valid / ready | index[1:0], data[7:0] (ready always high)
//
// One character is taken per cycle while the job queue has room; a request
// yields zero to four responses, sent one per cycle from the back end while
// rsp_bus takes them. The first response of a request is presented after the
// job is queued, loaded into the back end and written to the output register.
// Reset is synchronous and clears CSRs to their defaults and all group state.
// A stalled response side fills the queue, which then drops req_bus.ready.
module base64_stream_decoder import b64d_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   b64d_req_if.sink      req_bus,
   b64d_rsp_if.source    rsp_bus,
   b64d_csr_if.sink      csr_bus
);

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_pop   (pop_ready),
      .job_head  (pop_job),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: hdl/b64d_front.sv
// b64d_front: accepts characters, maps them to 6-bit values, builds groups
// and pushes byte/status jobs. Holds the CSRs. Depends on b64d_pkg, b64d_if.
module b64d_front import b64d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   b64d_req_if.sink      req_bus,
   b64d_csr_if.sink      csr_bus,
   output logic          push_valid,
   input  logic          push_ready,
   output job_type       push_job
);

   logic [CHAR_W-1:0]  c62_ff, c62_in;
   logic [CHAR_W-1:0]  c63_ff, c63_in;
   logic [CHAR_W-1:0]  pad_ff, pad_in;
   logic [GROUP_W-1:0] bits_ff, bits_in;
   logic [1:0]         pos_ff, pos_in;
   logic [1:0]         last_real_ff, last_real_in;
   logic               discard_ff, discard_in;

   logic               accept;
   logic               csr_write;
   logic [CHAR_W-1:0]  code;
   logic               is_pad;
   logic               is_bad;
   logic [5:0]         value;
   logic [CHAR_W-1:0]  offset_code;
   logic [GROUP_W-1:0] new_bits;
   logic [1:0]         new_pos;
   logic [1:0]         new_last;

   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid & req_bus.ready;
   assign csr_write     = csr_bus.valid & csr_bus.ready;
   assign code          = req_bus.char_code;

   // CSR writes; an index past the list is dropped
   always_comb begin
      c62_in = c62_ff;
      c63_in = c63_ff;
      pad_in = pad_ff;
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_CHAR_62: c62_in = csr_bus.data;
            CSR_CHAR_63: c63_in = csr_bus.data;
            CSR_PAD:     pad_in = csr_bus.data;
            default:     ;
         endcase
      end
   end

   // Character map; pad beats 63, 63 beats 62, 62 beats the alphabet
   always_comb begin
      is_pad      = 1'b0;
      is_bad      = 1'b0;
      value       = 6'd0;
      offset_code = '0;
      if (code == pad_ff) begin
         is_pad = 1'b1;
      end else if (code == c63_ff) begin
         value = 6'd63;
      end else if (code == c62_ff) begin
         value = 6'd62;
      end else if (code >= 8'd65 && code <= 8'd90) begin
         offset_code = code - 8'd65;
         value       = offset_code[5:0];
      end else if (code >= 8'd97 && code <= 8'd122) begin
         offset_code = code - 8'd71;
         value       = offset_code[5:0];
      end else if (code >= 8'd48 && code <= 8'd57) begin
         offset_code = code + 8'd4;
         value       = offset_code[5:0];
      end else begin
         is_bad = 1'b1;
      end
   end

   assign new_bits = {bits_ff[GROUP_W-7:0], (is_pad ? 6'd0 : value)};
   assign new_pos  = pos_ff + 2'd1;
   assign new_last = is_pad ? last_real_ff : pos_ff;

   // Group state and job generation
   always_comb begin
      bits_in      = bits_ff;
      pos_in       = pos_ff;
      last_real_in = last_real_ff;
      discard_in   = discard_ff;
      push_valid   = 1'b0;
      push_job     = '{group: '0, byte_count: 2'd0, has_status: 1'b0, status: STATUS_OK};
      if (accept) begin
         if (discard_ff) begin
            // skip the rest of a broken message
            if (req_bus.end_of_message) begin
               discard_in = 1'b0;
            end
         end else if (is_bad) begin
            bits_in             = '0;
            pos_in              = 2'd0;
            last_real_in        = 2'd0;
            discard_in          = ~req_bus.end_of_message;
            push_job.has_status = 1'b1;
            push_job.status     = STATUS_ILLEGAL;
            push_valid          = 1'b1;
         end else begin
            bits_in      = new_bits;
            pos_in       = new_pos;
            last_real_in = new_last;
            // full group: emit bytes up to the last real character
            if (new_pos == 2'd0) begin
               push_job.group      = new_bits;
               push_job.byte_count = new_last;
               bits_in             = '0;
               last_real_in        = 2'd0;
               push_valid          = (new_last != 2'd0);
            end
            if (req_bus.end_of_message) begin
               push_job.has_status = 1'b1;
               push_job.status     = (new_pos != 2'd0) ? STATUS_LENGTH : STATUS_OK;
               bits_in             = '0;
               pos_in              = 2'd0;
               last_real_in        = 2'd0;
               push_valid          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c62_ff       <= CHAR_62_RESET;
         c63_ff       <= CHAR_63_RESET;
         pad_ff       <= PAD_RESET;
         bits_ff      <= '0;
         pos_ff       <= 2'd0;
         last_real_ff <= 2'd0;
         discard_ff   <= 1'b0;
      end else begin
         c62_ff       <= c62_in;
         c63_ff       <= c63_in;
         pad_ff       <= pad_in;
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         last_real_ff <= last_real_in;
         discard_ff   <= discard_in;
      end
   end

endmodule

FILE: hdl/b64d_queue.sv
// b64d_queue: small job FIFO between the front and back ends.
// Depends on b64d_pkg for the job type.
module b64d_queue import b64d_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/b64d_back.sv
// b64d_back: takes jobs from the queue and sends their bytes and status
// one response per cycle while rsp_bus takes them, via an output register. Depends on b64d_pkg, b64d_if.
module b64d_back import b64d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   output logic          job_pop,
   input  job_type       job_head,
   b64d_rsp_if.source    rsp_bus
);

   job_type           cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [1:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] data_ff;
   logic              is_status_ff;
   status_type        status_ff;
   logic              last_ff;

   logic              out_free;
   logic              emit;
   logic              last_now;
   logic              is_byte;
   logic [2:0]        total;
   logic [CHAR_W-1:0] byte_sel;

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign emit     = cur_valid_ff & out_free;
   assign total    = {1'b0, cur_ff.byte_count} + {2'b00, cur_ff.has_status};
   assign last_now = (({1'b0, idx_ff} + 3'd1) == total);
   assign is_byte  = (idx_ff < cur_ff.byte_count);
   assign job_pop  = job_valid & (~cur_valid_ff | (emit & last_now));

   // Bytes leave most significant first
   always_comb begin
      case (idx_ff)
         2'd0:    byte_sel = cur_ff.group[23:16];
         2'd1:    byte_sel = cur_ff.group[15:8];
         default: byte_sel = cur_ff.group[7:0];
      endcase
   end

   // Current job and output slot control
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (job_pop) begin
         cur_in       = job_head;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (emit && last_now) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         data_ff      <= is_byte ? byte_sel : '0;
         is_status_ff <= ~is_byte;
         status_ff    <= is_byte ? STATUS_OK : cur_ff.status;
         last_ff      <= last_now;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.data_byte   = data_ff;
   assign rsp_bus.is_status   = is_status_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule
